[design/mst_pkg.sv]
package mst_pkg;

  // Field widths of one item
  localparam int unsigned KindW  = 2;
  localparam int unsigned PosW   = 10;
  localparam int unsigned ValW   = 32;
  localparam int unsigned RangeW = 11;

  // Item kinds; the remaining code is unused and answers zero
  typedef enum logic [KindW-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

endpackage

[design/mst_ram.sv]
module mst_ram #(
  parameter int unsigned AddrW = 11
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [mst_pkg::ValW-1:0]  wr_data_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [mst_pkg::ValW-1:0]  rd_data_o
);
  import mst_pkg::*;

  logic [ValW-1:0] mem [2**AddrW];
  logic [ValW-1:0] rd_data_q;

  // One write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // One registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/max_segment_tree_unit.sv]
// Max segment tree over LEAVES unsigned 32-bit leaves, held in one memory of 2*P
// nodes (P is LEAVES rounded up to a power of two) with one write and one
// registered read port. Every item gives exactly one result. An update handles
// one tree level per cycle. A query takes two steps per level, since each level
// may need up to two node reads through the single read port. A clear writes
// zero to every node, one a cycle. After reset the same clearing pass runs
// before the first item is accepted. A single max comparator, fed by the read
// port, does all the value arithmetic. The block takes one item at a time; a
// finished result waits in the output register while the next item is accepted.
module max_segment_tree_unit #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mst_pkg::KindW-1:0]   kind_i,
  input  logic [mst_pkg::PosW-1:0]    position_i,
  input  logic [mst_pkg::ValW-1:0]    new_value_i,
  input  logic [mst_pkg::RangeW-1:0]  range_start_i,
  input  logic [mst_pkg::RangeW-1:0]  range_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mst_pkg::ValW-1:0]    result_value_o
);
  import mst_pkg::*;

  localparam int unsigned LeafW    = $clog2(LEAVES);
  localparam int unsigned NodeBase = 2**LeafW;
  localparam int unsigned AddrW    = LeafW + 1;
  localparam int unsigned QW       = AddrW + 1;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ULEAF = 7'b0000100,
    S_UUP   = 7'b0001000,
    S_QLO   = 7'b0010000,
    S_QHI   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic              clr_item_q, clr_item_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic [AddrW-1:0]  node_q, node_d;
  logic [QW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [ValW-1:0]   acc_q, acc_d;
  logic [ValW-1:0]   res_q, res_d;
  logic [ValW-1:0]   out_data_q, out_data_d;

  logic              wr_en;
  logic [AddrW-1:0]  wr_addr, rd_addr, parent;
  logic [ValW-1:0]   wr_data, rd_data, max_val;
  logic [QW-1:0]     hi_m1, hi_t;
  logic [31:0]       lo_ext, hi_clamp;
  logic              pos_ok;
  logic [AddrW-1:0]  leaf_node;

  mst_ram #(
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Shared max unit: fold the node just read into the running value
  assign max_val = (rd_data > acc_q) ? rd_data : acc_q;

  // Decode the incoming item
  assign pos_ok    = 32'(position_i) < 32'(LEAVES);
  assign leaf_node = AddrW'(32'(NodeBase) + 32'(position_i));
  assign lo_ext    = 32'(range_start_i);
  assign hi_clamp  = (32'(range_end_i) > 32'(LEAVES)) ? 32'(LEAVES) : 32'(range_end_i);

  assign parent = node_q >> 1;
  assign hi_m1  = hi_q - QW'(1);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    clr_item_d  = clr_item_q;
    pend_d      = 1'b0;
    node_d      = node_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    acc_d       = pend_q ? max_val : acc_q;
    res_d       = res_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    wr_en       = 1'b0;
    wr_addr     = node_q;
    wr_data     = max_val;
    rd_addr     = node_q;
    hi_t        = hi_q;

    unique case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AddrW'(1);
        if (clr_q == '1) begin
          res_d   = '0;
          state_d = clr_item_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (kind_e'(kind_i))
            KIND_CLEAR: begin
              clr_d      = '0;
              clr_item_d = 1'b1;
              state_d    = S_CLEAR;
            end
            KIND_UPDATE: begin
              if (pos_ok) begin
                acc_d   = new_value_i;
                node_d  = leaf_node;
                rd_addr = leaf_node;
                pend_d  = 1'b1;
                state_d = S_ULEAF;
              end else begin
                res_d   = '0;
                state_d = S_RESP;
              end
            end
            KIND_QUERY: begin
              if (lo_ext < hi_clamp) begin
                lo_d    = QW'(lo_ext + 32'(NodeBase));
                hi_d    = QW'(hi_clamp + 32'(NodeBase));
                acc_d   = '0;
                state_d = S_QLO;
              end else begin
                res_d   = '0;
                state_d = S_RESP;
              end
            end
            default: begin
              res_d   = '0;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_ULEAF: begin
        // Write the raised leaf and fetch its sibling
        wr_en   = 1'b1;
        wr_addr = node_q;
        res_d   = max_val;
        rd_addr = {node_q[AddrW-1:1], ~node_q[0]};
        pend_d  = 1'b1;
        state_d = S_UUP;
      end
      S_UUP: begin
        // Write the parent, then fetch the parent's sibling
        wr_en   = 1'b1;
        wr_addr = parent;
        node_d  = parent;
        if (parent == AddrW'(1)) begin
          state_d = S_RESP;
        end else begin
          rd_addr = {parent[AddrW-1:1], ~parent[0]};
          pend_d  = 1'b1;
        end
      end
      S_QLO: begin
        if (lo_q < hi_q) begin
          if (lo_q[0]) begin
            rd_addr = lo_q[AddrW-1:0];
            pend_d  = 1'b1;
            lo_d    = lo_q + QW'(1);
          end
          state_d = S_QHI;
        end else begin
          res_d   = acc_d;
          state_d = S_RESP;
        end
      end
      S_QHI: begin
        if (hi_q[0]) begin
          rd_addr = hi_m1[AddrW-1:0];
          pend_d  = 1'b1;
          hi_t    = hi_m1;
        end
        lo_d    = lo_q >> 1;
        hi_d    = hi_t >> 1;
        state_d = S_QLO;
      end
      S_RESP: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          clr_item_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clr_item_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_item_q  <= clr_item_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    acc_q      <= acc_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_data_q;

endmodule
